[hdl/tsam_pkg.sv]
// Shared types and constants for the touch sample averaging and mapping block.
// Holds the transfer payload structs, command and register codes, and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package tsam_pkg;

    localparam int VAL_W = 12;
    localparam int SUM_W = 14;

    // Command codes of an input transfer.
    localparam logic [1:0] CMD_SET_X     = 2'd0;
    localparam logic [1:0] CMD_SET_Y     = 2'd1;
    localparam logic [1:0] CMD_SET_PRESS = 2'd2;
    localparam logic [1:0] CMD_SYNC      = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_TOP    = 2'd2;
    localparam logic [1:0] REG_BOTTOM = 2'd3;

    localparam logic [VAL_W-1:0] PEN_UP   = 12'd0;
    localparam logic [VAL_W-1:0] PEN_DOWN = 12'd1;

    localparam logic [2:0] FIRST_SUMMED = 3'd3;
    localparam logic [2:0] LAST_SUMMED  = 3'd5;
    localparam logic [2:0] COUNT_LIMIT  = 3'd6;
    localparam logic [1:0] SWAP_SAMPLES = 2'd3;

    typedef struct packed {
        logic [1:0]       command;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [9:0]       pixel_x;
        logic [8:0]       pixel_y;
        logic [VAL_W-1:0] raw_avg_x;
        logic [VAL_W-1:0] raw_avg_y;
        logic [1:0]       samples_used;
        logic             divide_fault;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG_X,
        S_AVG_Y,
        S_MAP_X,
        S_DIV_X,
        S_MAP_Y,
        S_DIV_Y,
        S_OUT
    } t_state;

endpackage

[hdl/touch_sample_average_and_map_top.sv]
// Touch sample averaging and edge-calibrated mapping to screen pixels.
// Uses tsam_pkg for payload structs, codes and sequencer states.
// One restoring divider is shared by both averages and both axes; one multiplier by both axes.
`timescale 1ns / 1ps
//
//  channel  | signals                          | direction | transfer when
//  ---------+----------------------------------+-----------+------------------------
//  event    | i_valid, o_ready, i_in           | in        | i_valid && o_ready
//  result   | o_valid, i_ready, o_out          | out       | o_valid && i_ready
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data  | in        | i_cfg_we
//
//  Latch commands and pen-down syncs are handled as they are accepted. A pen-up sync runs up to four
//  divisions on the shared restoring divider: the X and Y averages, then for each axis a
//  map step and, where needed, its division, then the output state.
//  Reset is synchronous and active low; it loads the edge registers with their defaults.
//  The result waits in an output register; a new event is taken while it waits, but a
//  second pen-up sync holds in the output state until the register is free.

module touch_sample_average_and_map_top #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480,
    parameter int SAMPLE_BITS   = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tsam_pkg::t_in_item   i_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tsam_pkg::t_out_item  o_out,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [11:0]          i_cfg_data
);

    import tsam_pkg::*;

    localparam int SCALE_XW = $clog2(SCREEN_WIDTH + 1);
    localparam int SCALE_YW = $clog2(SCREEN_HEIGHT + 1);
    localparam int SCALE_W  = (SCALE_XW > SCALE_YW) ? SCALE_XW : SCALE_YW;
    localparam int MUL_W    = SCALE_W + VAL_W;
    localparam int DIV_W    = (MUL_W > SUM_W) ? MUL_W : SUM_W;
    localparam int CNT_W    = $clog2(DIV_W + 1);

    localparam logic [SCALE_W-1:0] SCALE_X = SCALE_W'(SCREEN_WIDTH);
    localparam logic [SCALE_W-1:0] SCALE_Y = SCALE_W'(SCREEN_HEIGHT);
    localparam logic [VAL_W-1:0] SAMPLE_MASK = (SAMPLE_BITS >= VAL_W) ? {VAL_W{1'b1}} :
        VAL_W'((32'd1 << SAMPLE_BITS) - 32'd1);

    // Configuration and touch state.
    logic [VAL_W-1:0] r_left, r_right, r_top, r_bottom;
    logic [VAL_W-1:0] r_latest_x, r_latest_y, r_latest_press;
    logic             r_started;
    logic [2:0]       r_down_cnt;
    logic [SUM_W-1:0] r_sum_x, r_sum_y;
    logic [1:0]       r_used_cnt;

    // Sequencer and working registers.
    t_state              r_state, n_state;
    logic [VAL_W-1:0]    r_ax, n_ax, r_ay, n_ay;
    logic [SCALE_W-1:0]  r_px, n_px, r_py, n_py;
    logic                r_fault, n_fault;

    // Shared divider.
    logic [DIV_W-1:0]    r_dvd;
    logic [VAL_W-1:0]    r_dvs;
    logic [VAL_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic                div_load;
    logic [DIV_W-1:0]    div_dvd;
    logic [VAL_W-1:0]    div_dvs;
    logic [VAL_W:0]      rem_sh;
    logic [VAL_W:0]      rem_sub;
    logic                rem_ge;

    // Output register.
    t_out_item r_out;
    logic      r_out_valid;
    logic      out_free;

    // Shared map datapath.
    logic [VAL_W-1:0]   map_na, map_nb, map_da, map_db;
    logic [SCALE_W-1:0] map_scale;
    logic [VAL_W:0]     num_d, den_d, num_neg, den_neg;
    logic [VAL_W-1:0]   num_mag, den_mag;
    logic               den_zero, num_zero, sign_diff, num_full;
    logic [MUL_W-1:0]   map_prod;

    logic             in_fire;
    logic [VAL_W-1:0] in_val;
    logic [2:0]       down_inc;
    logic             clear_touch;

    assign o_ready     = (r_state == S_IDLE);
    assign in_fire     = i_valid && o_ready;
    assign in_val      = i_in.value & SAMPLE_MASK;
    assign down_inc    = r_down_cnt + 3'd1;
    assign out_free    = !r_out_valid || i_ready;
    assign clear_touch = (r_state == S_OUT) && out_free;

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= 12'd4095;
            r_right  <= 12'd0;
            r_top    <= 12'd0;
            r_bottom <= 12'd4095;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LEFT:   r_left   <= i_cfg_data;
                REG_RIGHT:  r_right  <= i_cfg_data;
                REG_TOP:    r_top    <= i_cfg_data;
                REG_BOTTOM: r_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Latches and touch accumulation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latest_x     <= '0;
            r_latest_y     <= '0;
            r_latest_press <= '0;
            r_started      <= 1'b0;
            r_down_cnt     <= 3'd1;
            r_sum_x        <= '0;
            r_sum_y        <= '0;
            r_used_cnt     <= '0;
        end else if (clear_touch) begin
            r_started  <= 1'b0;
            r_down_cnt <= 3'd1;
            r_sum_x    <= '0;
            r_sum_y    <= '0;
            r_used_cnt <= '0;
        end else if (in_fire) begin
            case (i_in.command)
                CMD_SET_X:     r_latest_x     <= in_val;
                CMD_SET_Y:     r_latest_y     <= in_val;
                CMD_SET_PRESS: r_latest_press <= in_val;
                CMD_SYNC: begin
                    if (r_latest_press == PEN_DOWN) begin
                        if (!r_started) begin
                            r_started <= 1'b1;
                        end else if (r_down_cnt < COUNT_LIMIT) begin
                            r_down_cnt <= down_inc;
                            if (down_inc >= FIRST_SUMMED && down_inc <= LAST_SUMMED) begin
                                r_sum_x    <= r_sum_x + SUM_W'(r_latest_x);
                                r_sum_y    <= r_sum_y + SUM_W'(r_latest_y);
                                r_used_cnt <= r_used_cnt + 2'd1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Map operand selection, shared by both axes.
    always_comb begin
        if (r_state == S_MAP_Y) begin
            map_na    = r_ay;
            map_nb    = r_top;
            map_da    = r_bottom;
            map_db    = r_top;
            map_scale = SCALE_Y;
        end else begin
            map_na    = r_left;
            map_nb    = r_ax;
            map_da    = r_left;
            map_db    = r_right;
            map_scale = SCALE_X;
        end
    end

    assign num_d     = {1'b0, map_na} - {1'b0, map_nb};
    assign den_d     = {1'b0, map_da} - {1'b0, map_db};
    assign num_neg   = '0 - num_d;
    assign den_neg   = '0 - den_d;
    assign num_mag   = num_d[VAL_W] ? num_neg[VAL_W-1:0] : num_d[VAL_W-1:0];
    assign den_mag   = den_d[VAL_W] ? den_neg[VAL_W-1:0] : den_d[VAL_W-1:0];
    assign den_zero  = (den_d == '0);
    assign num_zero  = (num_d == '0);
    assign sign_diff = num_d[VAL_W] ^ den_d[VAL_W];
    // A ratio of one or more, with numerator and divisor of the same sign, clamps to the full screen size.
    assign num_full  = (num_mag >= den_mag);
    assign map_prod  = MUL_W'(map_scale) * MUL_W'(num_mag);

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_ax     = r_ax;
        n_ay     = r_ay;
        n_px     = r_px;
        n_py     = r_py;
        n_fault  = r_fault;
        div_load = 1'b0;
        div_dvd  = '0;
        div_dvs  = '0;
        case (r_state)
            S_IDLE: begin
                if (in_fire && i_in.command == CMD_SYNC && r_latest_press == PEN_UP) begin
                    n_fault = 1'b0;
                    if (r_used_cnt == 2'd0) begin
                        n_ax    = '0;
                        n_ay    = '0;
                        n_state = S_MAP_X;
                    end else begin
                        div_load = 1'b1;
                        div_dvd  = DIV_W'((r_used_cnt == SWAP_SAMPLES) ? r_sum_y : r_sum_x);
                        div_dvs  = VAL_W'(r_used_cnt);
                        n_state  = S_AVG_X;
                    end
                end
            end
            S_AVG_X: begin
                if (r_cnt == '0) begin
                    n_ax     = r_dvd[VAL_W-1:0];
                    div_load = 1'b1;
                    div_dvd  = DIV_W'((r_used_cnt == SWAP_SAMPLES) ? r_sum_x : r_sum_y);
                    div_dvs  = VAL_W'(r_used_cnt);
                    n_state  = S_AVG_Y;
                end
            end
            S_AVG_Y: begin
                if (r_cnt == '0) begin
                    n_ay    = r_dvd[VAL_W-1:0];
                    n_state = S_MAP_X;
                end
            end
            S_MAP_X, S_MAP_Y: begin
                if (den_zero) begin
                    n_fault = 1'b1;
                end
                if (den_zero || num_zero || sign_diff || !num_full) begin
                    if (r_state == S_MAP_X) begin
                        n_px = '0;
                    end else begin
                        n_py = '0;
                    end
                end else begin
                    if (r_state == S_MAP_X) begin
                        n_px = map_scale;
                    end else begin
                        n_py = map_scale;
                    end
                end
                if (!den_zero && !num_zero && !sign_diff && !num_full) begin
                    div_load = 1'b1;
                    div_dvd  = DIV_W'(map_prod);
                    div_dvs  = den_mag;
                    n_state  = (r_state == S_MAP_X) ? S_DIV_X : S_DIV_Y;
                end else begin
                    n_state  = (r_state == S_MAP_X) ? S_MAP_Y : S_OUT;
                end
            end
            S_DIV_X: begin
                if (r_cnt == '0) begin
                    n_px    = r_dvd[SCALE_W-1:0];
                    n_state = S_MAP_Y;
                end
            end
            S_DIV_Y: begin
                if (r_cnt == '0) begin
                    n_py    = r_dvd[SCALE_W-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax    <= n_ax;
        r_ay    <= n_ay;
        r_px    <= n_px;
        r_py    <= n_py;
        r_fault <= n_fault;
    end

    // Restoring divider: one quotient bit per cycle, quotient shifts into the dividend.
    assign rem_sh  = {r_rem, r_dvd[DIV_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_dvs});
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (div_load) begin
            r_cnt <= CNT_W'(DIV_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_load) begin
            r_dvd <= div_dvd;
            r_dvs <= div_dvs;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DIV_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
        end
    end

    // Output register.
    logic [SCALE_W+9:0] px_ext;
    logic [SCALE_W+8:0] py_ext;
    assign px_ext = {10'd0, r_px};
    assign py_ext = {9'd0, r_py};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (clear_touch) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clear_touch) begin
            r_out.pixel_x      <= px_ext[9:0];
            r_out.pixel_y      <= py_ext[8:0];
            r_out.raw_avg_x    <= r_ax;
            r_out.raw_avg_y    <= r_ay;
            r_out.samples_used <= r_used_cnt;
            r_out.divide_fault <= r_fault;
        end
    end

    a_used_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_down_cnt <= 3'd2) |-> (r_used_cnt == 2'd0))
        else $error("samples counted before the third pen-down sync");

    a_used_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_down_cnt == COUNT_LIMIT) |-> (r_used_cnt == SWAP_SAMPLES))
        else $error("saturated touch does not hold three samples");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_load |-> (div_dvs != '0))
        else $error("divider started with a zero divisor");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not presented after the output state");

    a_pixel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_px <= SCALE_X && r_py <= SCALE_Y))
        else $error("mapped pixel beyond the screen range");

endmodule

[tb/tb_touch_sample_average_and_map_top.sv]
// Self-checking testbench for touch_sample_average_and_map_top.
// Needs tsam_pkg and the top module. A directed table runs first, then random touch
// sequences under several edge settings, checked against table values or a local predictor.
`timescale 1ns / 1ps

module tb_touch_sample_average_and_map_top;

    import tsam_pkg::*;

    localparam int SCREEN_W    = 800;
    localparam int SCREEN_H    = 480;
    localparam int SETTLE      = 120;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DIR_ROWS    = 33;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 125;

    localparam bit ROW_EVENT = 1'b0;
    localparam bit ROW_CFG   = 1'b1;

    typedef struct packed {
        bit          is_cfg;
        logic [1:0]  code;
        logic [11:0] value;
        bit          typed;
        t_out_item   want;
    } t_dir_row;

    localparam t_out_item NO_POINT = '0;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        o_ready;
    t_in_item    i_in       = '0;
    logic        o_valid;
    logic        i_ready    = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = '0;
    logic [11:0] i_cfg_data = '0;

    // Predictor state.
    logic [11:0] cfg_edge [4];
    logic [11:0] seen_x, seen_y, seen_press;
    bit          touch_on;
    logic [2:0]  down_cnt;
    int          acc_x, acc_y;
    logic [1:0]  used_cnt;

    t_out_item   expected_points [$];
    int          items_sent    = 0;
    int          points_checked = 0;
    int          settings_used = 0;
    int          error_count   = 0;
    int          cycle_count   = 0;
    int          burst_left    = 0;
    int          stall_left    = 0;
    int          stall_mode    = 0;

    t_dir_row    dir_rows [DIR_ROWS];

    touch_sample_average_and_map_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** touch_sample_average_and_map_top: FAILED **");
            $finish;
        end
    end

    // span*num/den truncated toward zero and clamped to 0..span; zero on a zero divisor.
    function automatic int scale_axis(input int span, input int num, input int den,
                                      inout bit fault);
        longint q;
        if (den == 0) begin
            fault = 1'b1;
            return 0;
        end
        q = (longint'(span) * num) / den;
        if (q < 0)
            q = 0;
        if (q > span)
            q = span;
        return int'(q);
    endfunction

    function automatic bit predict_touch(input t_in_item ev, output t_out_item pt);
        int ax, ay;
        bit fault;
        pt = '0;
        fault = 1'b0;
        case (ev.command)
            CMD_SET_X: begin
                seen_x = ev.value;
                return 1'b0;
            end
            CMD_SET_Y: begin
                seen_y = ev.value;
                return 1'b0;
            end
            CMD_SET_PRESS: begin
                seen_press = ev.value;
                return 1'b0;
            end
            default: ;
        endcase

        if (seen_press == PEN_DOWN) begin
            if (!touch_on) begin
                touch_on = 1'b1;
            end else if (down_cnt < COUNT_LIMIT) begin
                down_cnt = down_cnt + 3'd1;
                if (down_cnt >= FIRST_SUMMED && down_cnt <= LAST_SUMMED) begin
                    acc_x += int'(seen_x);
                    acc_y += int'(seen_y);
                    used_cnt = used_cnt + 2'd1;
                end
            end
            return 1'b0;
        end
        if (seen_press != PEN_UP)
            return 1'b0;

        // A full set of samples comes out with X and Y exchanged.
        if (used_cnt >= SWAP_SAMPLES) begin
            ax = acc_y / int'(SWAP_SAMPLES);
            ay = acc_x / int'(SWAP_SAMPLES);
        end else if (used_cnt != 2'd0) begin
            ax = acc_x / int'(used_cnt);
            ay = acc_y / int'(used_cnt);
        end else begin
            ax = 0;
            ay = 0;
        end

        pt.pixel_x = 10'(scale_axis(SCREEN_W, int'(cfg_edge[REG_LEFT]) - ax,
                     int'(cfg_edge[REG_LEFT]) - int'(cfg_edge[REG_RIGHT]), fault));
        pt.pixel_y = 9'(scale_axis(SCREEN_H, ay - int'(cfg_edge[REG_TOP]),
                     int'(cfg_edge[REG_BOTTOM]) - int'(cfg_edge[REG_TOP]), fault));
        pt.raw_avg_x    = 12'(ax);
        pt.raw_avg_y    = 12'(ay);
        pt.samples_used = used_cnt;
        pt.divide_fault = fault;

        touch_on = 1'b0;
        down_cnt = 3'd1;
        acc_x    = 0;
        acc_y    = 0;
        used_cnt = 2'd0;
        return 1'b1;
    endfunction

    function automatic logic [11:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return 12'd4095;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // The sender works in bursts; a gap of idle cycles may precede each burst.
    task automatic send_event(input logic [1:0] cmd, input logic [11:0] val,
                              input bit typed, input t_out_item typed_pt);
        t_in_item  ev;
        t_out_item pt;
        int        gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        ev.command = cmd;
        ev.value   = val;
        i_valid <= 1'b1;
        i_in    <= ev;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (predict_touch(ev, pt) || typed)
            expected_points.push_back(typed ? typed_pt : pt);
    endtask

    // Holds the sender off until every expected point is out, then lets the
    // divider finish anything that produces no result.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic program_edge(input logic [1:0] idx, input logic [11:0] data, input bit last);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        cfg_edge[idx] = data;
        if (last)
            i_cfg_we <= 1'b0;
    endtask

    task automatic send_touch();
        int syncs;
        if ($urandom_range(0, 3) == 0)
            send_event(CMD_SET_X, rand_sample(), 1'b0, NO_POINT);
        send_event(CMD_SET_PRESS, PEN_DOWN, 1'b0, NO_POINT);
        syncs = $urandom_range(0, 8);
        repeat (syncs) begin
            if ($urandom_range(0, 3) != 0)
                send_event(CMD_SET_X, rand_sample(), 1'b0, NO_POINT);
            if ($urandom_range(0, 3) != 0)
                send_event(CMD_SET_Y, rand_sample(), 1'b0, NO_POINT);
            send_event(CMD_SYNC, 12'd0, 1'b0, NO_POINT);
        end
        // Now and then a sync under an unusable pressure reading.
        if ($urandom_range(0, 5) == 0) begin
            send_event(CMD_SET_PRESS, 12'($urandom_range(2, 4095)), 1'b0, NO_POINT);
            send_event(CMD_SYNC, rand_sample(), 1'b0, NO_POINT);
        end
        send_event(CMD_SET_PRESS, PEN_UP, 1'b0, NO_POINT);
        send_event(CMD_SYNC, rand_sample(), 1'b0, NO_POINT);
    endtask

    // Result side: stall pattern and point checking.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_points.size() == 0) begin
                $error("unexpected point: pixel_x %0d pixel_y %0d", o_out.pixel_x,
                       o_out.pixel_y);
                error_count++;
            end else begin
                want = expected_points.pop_front();
                points_checked++;
                if (o_out.pixel_x !== want.pixel_x) begin
                    $error("pixel_x: expected %0d, got %0d", want.pixel_x, o_out.pixel_x);
                    error_count++;
                end
                if (o_out.pixel_y !== want.pixel_y) begin
                    $error("pixel_y: expected %0d, got %0d", want.pixel_y, o_out.pixel_y);
                    error_count++;
                end
                if (o_out.raw_avg_x !== want.raw_avg_x) begin
                    $error("raw_avg_x: expected %0d, got %0d", want.raw_avg_x,
                           o_out.raw_avg_x);
                    error_count++;
                end
                if (o_out.raw_avg_y !== want.raw_avg_y) begin
                    $error("raw_avg_y: expected %0d, got %0d", want.raw_avg_y,
                           o_out.raw_avg_y);
                    error_count++;
                end
                if (o_out.samples_used !== want.samples_used) begin
                    $error("samples_used: expected %0d, got %0d", want.samples_used,
                           o_out.samples_used);
                    error_count++;
                end
                if (o_out.divide_fault !== want.divide_fault) begin
                    $error("divide_fault: expected %0d, got %0d", want.divide_fault,
                           o_out.divide_fault);
                    error_count++;
                end
            end
        end

        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(32, 256);
        end
        stall_left--;
        case (stall_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    initial begin : stimulus
        t_dir_row    row;
        logic [11:0] new_edges [4];
        int          n, phase, r, phase_start;

        cfg_edge[REG_LEFT]   = 12'd4095;
        cfg_edge[REG_RIGHT]  = 12'd0;
        cfg_edge[REG_TOP]    = 12'd0;
        cfg_edge[REG_BOTTOM] = 12'd4095;
        seen_x     = '0;
        seen_y     = '0;
        seen_press = '0;
        touch_on   = 1'b0;
        down_cnt   = 3'd1;
        acc_x      = 0;
        acc_y      = 0;
        used_cnt   = 2'd0;

        dir_rows = '{
            // Pen-up with no touch at the reset edges.
            '{ROW_EVENT, CMD_SYNC,      12'd0,    1'b1, '{10'd800, 9'd0, 12'd0, 12'd0, 2'd0, 1'b0}},
            // Full-scale touch held past the count limit.
            '{ROW_EVENT, CMD_SET_X,     12'd4095, 1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SET_Y,     12'd4095, 1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SET_PRESS, PEN_DOWN, 1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SYNC,      12'd0,    1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SYNC,      12'd0,    1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SYNC,      12'd0,    1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SYNC,      12'd0,    1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SYNC,      12'd0,    1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SYNC,      12'd0,    1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SYNC,      12'd4095, 1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SET_PRESS, PEN_UP,   1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SYNC,      12'd0,    1'b1,
              '{10'd0, 9'd480, 12'd4095, 12'd4095, 2'd3, 1'b0}},
            // A sync under an out-of-range pressure does nothing.
            '{ROW_EVENT, CMD_SET_PRESS, 12'd4095, 1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SYNC,      12'd0,    1'b0, NO_POINT},
            // Single summed sample.
            '{ROW_EVENT, CMD_SET_PRESS, PEN_DOWN, 1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SYNC,      12'd0,    1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SYNC,      12'd0,    1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SET_X,     12'd123,  1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SET_Y,     12'd2222, 1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SYNC,      12'd0,    1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SET_PRESS, PEN_UP,   1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SYNC,      12'd0,    1'b0, NO_POINT},
            // Equal edge pairs on both axes.
            '{ROW_CFG,   REG_LEFT,      12'd2048, 1'b0, NO_POINT},
            '{ROW_CFG,   REG_RIGHT,     12'd2048, 1'b0, NO_POINT},
            '{ROW_CFG,   REG_TOP,       12'd100,  1'b0, NO_POINT},
            '{ROW_CFG,   REG_BOTTOM,    12'd100,  1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SYNC,      12'd0,    1'b1, '{10'd0, 9'd0, 12'd0, 12'd0, 2'd0, 1'b1}},
            // Both axes inverted at full scale: negative divisors, a zero numerator on X, a negative one on Y.
            '{ROW_CFG,   REG_LEFT,      12'd0,    1'b0, NO_POINT},
            '{ROW_CFG,   REG_RIGHT,     12'd4095, 1'b0, NO_POINT},
            '{ROW_CFG,   REG_TOP,       12'd4095, 1'b0, NO_POINT},
            '{ROW_CFG,   REG_BOTTOM,    12'd0,    1'b0, NO_POINT},
            '{ROW_EVENT, CMD_SYNC,      12'd0,    1'b1, '{10'd0, 9'd480, 12'd0, 12'd0, 2'd0, 1'b0}}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < DIR_ROWS; n++) begin
            row = dir_rows[n];
            if (row.is_cfg) begin
                if (!dir_rows[n - 1].is_cfg) begin
                    wait_for_drain();
                    settings_used++;
                end
                program_edge(row.code, row.value, n == DIR_ROWS - 1 || !dir_rows[n + 1].is_cfg);
            end else begin
                send_event(row.code, row.value, row.typed, row.want);
            end
        end

        // Edge order in new_edges: left, right, top, bottom.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: new_edges = '{12'd4095, 12'd0, 12'd0, 12'd4095};
                1: new_edges = '{12'd3500, 12'd600, 12'd400, 12'd3600};
                2: begin
                    new_edges = '{rand_sample(), 12'd0, rand_sample(), rand_sample()};
                    new_edges[REG_RIGHT] = new_edges[REG_LEFT];
                end
                3: begin
                    new_edges = '{rand_sample(), rand_sample(), rand_sample(), 12'd0};
                    new_edges[REG_BOTTOM] = new_edges[REG_TOP];
                end
                4: new_edges = '{12'd0, 12'd0, 12'd0, 12'd0};
                5: new_edges = '{12'd4095, 12'd4095, 12'd4095, 12'd4095};
                6: new_edges = '{12'd0, 12'd4095, 12'd4095, 12'd0};
                default: begin
                    for (r = REG_LEFT; r <= REG_BOTTOM; r++)
                        new_edges[r] = 12'($urandom_range(0, 4095));
                end
            endcase
            wait_for_drain();
            settings_used++;
            for (r = REG_LEFT; r <= REG_BOTTOM; r++)
                program_edge(2'(r), new_edges[r], r == REG_BOTTOM);

            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) != 0)
                    send_touch();
                else
                    send_event(2'($urandom_range(0, 3)),
                               ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 1))
                                                           : 12'($urandom_range(0, 4095)),
                               1'b0, NO_POINT);
            end
        end

        wait_for_drain();

        $display("Sent %0d touch events under %0d edge settings; %0d mapped points compared.",
                 items_sent, settings_used + 1, points_checked);
        if (error_count == 0)
            $display("** touch_sample_average_and_map_top: PASSED **");
        else
            $display("** touch_sample_average_and_map_top: FAILED **");
        $finish;
    end

endmodule

[files.f]
hdl/tsam_pkg.sv
hdl/touch_sample_average_and_map_top.sv
tb/tb_touch_sample_average_and_map_top.sv
